/* src/spq_pkg.sv */
// shared types and codes for the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int COUNT_W = 5;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] sequence_number;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  glyph;
		logic [7:0]  heading;
		logic        player_flag;
		logic        npc_flag;
		logic        battled_flag;
	} entry_t;

	// command broadcast to every cell in the chain
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t new_entry;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* src/sorted_priority_queue_top.sv */
// top level of the sorted priority queue: cell chain, count and result register
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of up to QUEUE_DEPTH entries held in a chain of cells,
// head in the first cell. Every cell compares its key with the pushed key in
// parallel and shifts right, takes the new entry or holds; a pop shifts the
// whole chain left. One item (push or pop) is taken per clock cycle and its
// result, which shows status, count and the new head, appears in the next
// cycle in an output register; the input is stalled only while that register
// holds a result that the output side is stalling. There is no clearing pass
// after reset: the queue is empty as soon as reset is released.
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [31:0] turn_key,
	input  wire logic [15:0] sequence_number,
	input  wire logic [7:0]  pos_x,
	input  wire logic [7:0]  pos_y,
	input  wire logic [7:0]  glyph,
	input  wire logic [7:0]  heading,
	input  wire logic        player_flag,
	input  wire logic        npc_flag,
	input  wire logic        battled_flag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             empty_res,
	output logic [COUNT_W-1:0] count,
	output logic [31:0]      head_key,
	output logic [15:0]      head_sequence,
	output logic [7:0]       head_x,
	output logic [7:0]       head_y,
	output logic [7:0]       head_glyph,
	output logic [7:0]       head_heading,
	output logic             head_player,
	output logic             head_npc,
	output logic             head_battled
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic          accept;
	logic          full;
	logic          empty;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_nxt;
	status_t       st_nxt;
	cell_cmd_t     cmd;
	logic          out_valid_q;

	entry_t              cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_valid;
	logic [QUEUE_DEPTH-1:0] cell_shift;
	entry_t              head_nxt;
	logic                head_nxt_valid;
	entry_t              head_res;
	logic [CW+COUNT_W-1:0] cnt_wide;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign full     = (cnt_q == DEPTH_C);
	assign empty    = (cnt_q == '0);

	always_comb begin
		cmd.new_entry.key             = turn_key;
		cmd.new_entry.sequence_number = sequence_number;
		cmd.new_entry.pos_x           = pos_x;
		cmd.new_entry.pos_y           = pos_y;
		cmd.new_entry.glyph           = glyph;
		cmd.new_entry.heading         = heading;
		cmd.new_entry.player_flag     = player_flag;
		cmd.new_entry.npc_flag        = npc_flag;
		cmd.new_entry.battled_flag    = battled_flag;
		cmd.push = accept && (op_t'(operation) == OP_PUSH) && !full;
		cmd.pop  = accept && (op_t'(operation) == OP_POP) && !empty;
	end

	always_comb begin
		st_nxt  = ST_OK;
		cnt_nxt = cnt_q;
		if (op_t'(operation) == OP_PUSH) begin
			if (full) begin
				st_nxt = ST_FULL;
			end else begin
				cnt_nxt = cnt_q + 1'b1;
			end
		end else begin
			if (empty) begin
				st_nxt = ST_EMPTY;
			end else begin
				cnt_nxt = cnt_q - 1'b1;
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_v;
		logic   left_s;
		entry_t right_e;
		logic   right_v;
		entry_t nxt_e;
		logic   nxt_v;

		if (i == 0) begin : g_first
			// head has an always-occupied, never-shifting left side
			assign left_e = cmd.new_entry;
			assign left_v = 1'b1;
			assign left_s = 1'b0;
			assign head_nxt       = nxt_e;
			assign head_nxt_valid = nxt_v;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_v = cell_valid[i-1];
			assign left_s = cell_shift[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = '0;
			assign right_v = 1'b0;
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
			assign right_v = cell_valid[i+1];
		end

		spq_cell #(
			.IS_HEAD (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e),
			.left_valid  (left_v),
			.left_shift  (left_s),
			.right_entry (right_e),
			.right_valid (right_v),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i]),
			.shift       (cell_shift[i]),
			.nxt_entry   (nxt_e),
			.nxt_valid   (nxt_v)
		);
	end

	// an empty queue reports a zero head
	assign head_res = head_nxt_valid ? head_nxt : '0;
	assign cnt_wide = {{COUNT_W{1'b0}}, cnt_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status        <= st_nxt;
			empty_res     <= (cnt_nxt == '0);
			count         <= cnt_wide[COUNT_W-1:0];
			head_key      <= head_res.key;
			head_sequence <= head_res.sequence_number;
			head_x        <= head_res.pos_x;
			head_y        <= head_res.pos_y;
			head_glyph    <= head_res.glyph;
			head_heading  <= head_res.heading;
			head_player   <= head_res.player_flag;
			head_npc      <= head_res.npc_flag;
			head_battled  <= head_res.battled_flag;
		end
	end

	assign out_valid = out_valid_q;

	// the number of occupied cells always equals the entry count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(cnt_q))
		else $error("cell valid bits disagree with entry count");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (cnt_q != '0))
		else $error("head cell occupancy disagrees with entry count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_t'(operation) == OP_PUSH) && full)
		|=> (status == ST_FULL) && (cnt_q == DEPTH_C))
		else $error("push on full queue was not dropped");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_t'(operation) == OP_POP) && empty)
		|=> (status == ST_EMPTY) && empty_res && (head_key == '0))
		else $error("pop on empty queue misreported");

endmodule

`default_nettype wire

/* src/spq_cell.sv */
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
	import spq_pkg::*;
#(
	parameter bit IS_HEAD = 1'b0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    left_entry,
	input  wire logic      left_valid,
	input  wire logic      left_shift,
	input  wire entry_t    right_entry,
	input  wire logic      right_valid,
	output entry_t         entry,
	output logic           valid,
	output logic           shift,
	output entry_t         nxt_entry,
	output logic           nxt_valid
);

	entry_t entry_q;
	logic   valid_q;
	logic   cmp;

	// the head lets an equal key stay in front, later slots do not
	assign cmp   = IS_HEAD ? (entry_q.key > cmd.new_entry.key)
	                       : (entry_q.key >= cmd.new_entry.key);
	assign shift = valid_q & cmp;

	always_comb begin
		nxt_entry = entry_q;
		nxt_valid = valid_q;
		if (cmd.push) begin
			if (left_shift) begin
				nxt_entry = left_entry;
				nxt_valid = 1'b1;
			end else if (shift || (!valid_q && left_valid)) begin
				nxt_entry = cmd.new_entry;
				nxt_valid = 1'b1;
			end
		end else if (cmd.pop) begin
			nxt_entry = right_entry;
			nxt_valid = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt_entry;
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

`default_nettype wire
